### sv/aip_pkg.sv
package aip_pkg;

    localparam int POSITION_WIDTH = 16;
    localparam int END_POS_WIDTH  = 16;
    localparam int POS_EXT_WIDTH  = (POSITION_WIDTH > END_POS_WIDTH) ?
                                    POSITION_WIDTH : END_POS_WIDTH;

    localparam logic [2:0] PH_SPACE  = 3'd0;
    localparam logic [2:0] PH_SIGNED = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_DIGITS = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_X  = 8'h78;

    localparam logic [5:0] BASE_AUTO = 6'd0;
    localparam logic [5:0] BASE_OCT  = 6'd8;
    localparam logic [5:0] BASE_DEC  = 6'd10;
    localparam logic [5:0] BASE_HEX  = 6'd16;

    typedef struct packed {
        logic       hit;
        logic [5:0] value;
    } digit_t;

    // Digit classes are tested in order: decimal, upper case, lower case.
    function automatic digit_t digit_of(input logic [7:0] c, input logic [5:0] b);
        digit_t     d;
        logic [7:0] dn;
        logic [3:0] lim;
        logic [8:0] up;
        logic [8:0] lo;
        d   = '0;
        dn  = c - CH_ZERO;
        lim = (b < BASE_DEC) ? b[3:0] : BASE_DEC[3:0];
        up  = {1'b0, c} - {1'b0, CH_UP_A} + 9'd10;
        lo  = {1'b0, c} - {1'b0, CH_LO_A} + 9'd10;
        if (c >= CH_ZERO && dn < {4'd0, lim})
        begin
            d.hit   = 1'b1;
            d.value = dn[5:0];
        end
        else if (c >= CH_UP_A && up < {3'd0, b})
        begin
            d.hit   = 1'b1;
            d.value = up[5:0];
        end
        else if (c >= CH_LO_A && lo < {3'd0, b})
        begin
            d.hit   = 1'b1;
            d.value = lo[5:0];
        end
        return d;
    endfunction

endpackage

### sv/ascii_integer_parser_core.sv
// Streaming strtol-style parser: one text byte per beat, one beat accepted every
// cycle. The parse state sits in registers and each byte is folded in by a single
// pass of logic (digit classify, one 32x6 multiply-add), so the rate is one byte
// per cycle, limited only by that multiply-add path. A result appears in the
// output register the cycle after the byte that ends the number; input stalls only
// while that register is full and the consumer stalls it. The radix register is
// sampled when the radix is decided, right after the optional sign.
module ascii_integer_parser_core
    import aip_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [5:0]               number_base,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [7:0]               character,
    input  logic                     first,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [31:0]       value,
    output logic [END_POS_WIDTH-1:0] end_position,
    output logic                     ended_on_nul
);

    logic [5:0]                base_cfg_reg;
    logic [2:0]                phase_reg, phase_next;
    logic                      neg_reg, neg_next;
    logic [5:0]                base_reg, base_next;
    logic [31:0]               acc_reg, acc_next;
    logic [POSITION_WIDTH-1:0] pos_reg, pos_next;

    logic                      out_valid_reg;
    logic [31:0]               value_reg, value_next;
    logic [END_POS_WIDTH-1:0]  end_pos_reg, end_pos_next;
    logic                      nul_reg;

    logic [2:0]                eff_phase;
    logic                      eff_neg;
    logic [5:0]                eff_base;
    logic [31:0]               eff_acc;
    logic [POSITION_WIDTH-1:0] eff_pos;
    logic [POSITION_WIDTH-1:0] pos_inc;
    logic [POS_EXT_WIDTH-1:0]  pos_ext;

    logic                      accept;
    logic                      do_digit;
    logic [5:0]                dig_base;
    digit_t                    dig;
    logic                      emit;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg & out_stall;
    assign accept    = in_valid & ~in_stall;

    // A first byte restarts the parse before it is looked at.
    assign eff_phase = first ? PH_SPACE : phase_reg;
    assign eff_neg   = first ? 1'b0 : neg_reg;
    assign eff_base  = first ? BASE_AUTO : base_reg;
    assign eff_acc   = first ? 32'd0 : acc_reg;
    assign eff_pos   = first ? '0 : pos_reg;
    assign pos_inc   = (eff_pos == {POSITION_WIDTH{1'b1}}) ? eff_pos : eff_pos + 1'b1;

    assign dig = digit_of(character, dig_base);

    always_comb
    begin
        phase_next = eff_phase;
        neg_next   = eff_neg;
        base_next  = eff_base;
        acc_next   = eff_acc;
        pos_next   = eff_pos;
        do_digit   = 1'b0;
        dig_base   = eff_base;
        emit       = 1'b0;
        case (eff_phase)
            PH_SPACE, PH_SIGNED:
            begin
                if (eff_phase == PH_SPACE &&
                    (character inside {CH_SPACE, [CH_TAB:CH_CR]}))
                begin
                    pos_next = pos_inc;
                end
                else if (eff_phase == PH_SPACE &&
                         (character inside {CH_PLUS, CH_MINUS}))
                begin
                    neg_next   = (character == CH_MINUS);
                    phase_next = PH_SIGNED;
                    pos_next   = pos_inc;
                end
                else if ((base_cfg_reg inside {BASE_AUTO, BASE_HEX}) &&
                         character == CH_ZERO)
                begin
                    base_next  = base_cfg_reg;
                    acc_next   = 32'd0;
                    phase_next = PH_ZERO;
                    pos_next   = pos_inc;
                end
                else
                begin
                    do_digit = 1'b1;
                    dig_base = (base_cfg_reg == BASE_AUTO) ? BASE_DEC : base_cfg_reg;
                end
            end
            PH_ZERO:
            begin
                if (character inside {CH_LO_X, CH_UP_X})
                begin
                    base_next  = BASE_HEX;
                    phase_next = PH_DIGITS;
                    pos_next   = pos_inc;
                end
                else
                begin
                    do_digit = 1'b1;
                    dig_base = (eff_base == BASE_AUTO) ? BASE_OCT : eff_base;
                end
            end
            PH_DIGITS:
            begin
                do_digit = 1'b1;
            end
            default:
            begin
                // hold until the next string starts
            end
        endcase

        if (do_digit)
        begin
            base_next = dig_base;
            if (dig.hit)
            begin
                acc_next   = eff_acc * {26'd0, dig_base} + {26'd0, dig.value};
                phase_next = PH_DIGITS;
                pos_next   = pos_inc;
            end
            else
            begin
                phase_next = PH_DONE;
                emit       = 1'b1;
            end
        end
    end

    assign pos_ext      = POS_EXT_WIDTH'(eff_pos);
    assign end_pos_next = (pos_ext > POS_EXT_WIDTH'({END_POS_WIDTH{1'b1}})) ?
                          {END_POS_WIDTH{1'b1}} : pos_ext[END_POS_WIDTH-1:0];
    assign value_next   = eff_neg ? (32'd0 - eff_acc) : eff_acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_cfg_reg  <= BASE_AUTO;
            phase_reg     <= PH_SPACE;
            neg_reg       <= 1'b0;
            base_reg      <= BASE_AUTO;
            acc_reg       <= 32'd0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                base_cfg_reg <= number_base;
            end
            if (accept)
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                base_reg  <= base_next;
                acc_reg   <= acc_next;
                pos_reg   <= pos_next;
            end
            if (accept && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result beat; no reset needed on payload.
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            value_reg   <= value_next;
            end_pos_reg <= end_pos_next;
            nul_reg     <= (character == CH_NUL);
        end
    end

    assign out_valid    = out_valid_reg;
    assign value        = value_reg;
    assign end_position = end_pos_reg;
    assign ended_on_nul = nul_reg;

endmodule

### sv/ascii_integer_parser_checker.sv
module ascii_integer_parser_checker
    import aip_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     cfg_ready,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic signed [31:0]       value,
    input logic [END_POS_WIDTH-1:0] end_position
);

    // Input may stall only behind a full, stalled result beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled with no result held");

    // A new result beat follows an accepted input beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall))
        else $error("result beat without an accepted input beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config write not taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
        (out_valid && $stable(value) && $stable(end_position)))
        else $error("stalled result beat changed");

endmodule

bind ascii_integer_parser_core ascii_integer_parser_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_ready    (cfg_ready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .value        (value),
    .end_position (end_position)
);

### dv/aip_checker.sv
`timescale 1ns / 1ps

module aip_checker
    import aip_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [5:0]               number_base,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic [7:0]               character,
    input  logic                     first,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic signed [31:0]       value,
    input  logic [END_POS_WIDTH-1:0] end_position,
    input  logic                     ended_on_nul,
    output int unsigned              mismatches,
    output int unsigned              outstanding,
    output int unsigned              numbers_checked
);

    localparam longint unsigned END_SAT = (64'd1 << END_POS_WIDTH) - 1;

    typedef struct packed {
        logic [31:0]              value;
        logic [END_POS_WIDTH-1:0] end_pos;
        logic                     nul;
    } parsed_number_t;

    parsed_number_t              expected_numbers[$];

    logic [5:0]                  radix_setting;
    logic [2:0]                  parse_phase;
    logic                        negative;
    logic [5:0]                  active_radix;
    logic [31:0]                 accum;
    logic [POSITION_WIDTH-1:0]   position;
    int unsigned                 err_count;
    int unsigned                 seen;

    function automatic void flag_mismatch(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endfunction

    function automatic void restart_parse();
        parse_phase  = PH_SPACE;
        negative     = 1'b0;
        active_radix = BASE_AUTO;
        accum        = '0;
        position     = '0;
    endfunction

    function automatic void bump_position();
        if (position != {POSITION_WIDTH{1'b1}})
            position = position + 1'b1;
    endfunction

    // Decimal digits first, then upper case, then lower case letters.
    function automatic bit digit_value(input logic [7:0] c, input logic [5:0] b,
                                       output int unsigned d);
        int unsigned ci;
        int unsigned bi;
        int unsigned lim;
        ci  = c;
        bi  = b;
        lim = (bi < 10) ? bi : 10;
        d   = 0;
        if (ci >= CH_ZERO && ci - CH_ZERO < lim)
        begin
            d = ci - CH_ZERO;
            return 1'b1;
        end
        if (ci >= CH_UP_A && ci - CH_UP_A + 10 < bi)
        begin
            d = ci - CH_UP_A + 10;
            return 1'b1;
        end
        if (ci >= CH_LO_A && ci - CH_LO_A + 10 < bi)
        begin
            d = ci - CH_LO_A + 10;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void take_digit(input logic [7:0] c);
        int unsigned     d;
        longint unsigned p;
        parsed_number_t  num;
        if (digit_value(c, active_radix, d))
        begin
            accum = accum * {26'd0, active_radix} + d[31:0];
            bump_position();
        end
        else
        begin
            p           = position;
            num.value   = negative ? -accum : accum;
            num.end_pos = END_POS_WIDTH'((p > END_SAT) ? END_SAT : p);
            num.nul     = (c == CH_NUL);
            expected_numbers.push_back(num);
            parse_phase = PH_DONE;
        end
    endfunction

    // Radix is fixed by the first byte after the optional sign.
    function automatic void pick_radix(input logic [7:0] c);
        if ((radix_setting == BASE_AUTO || radix_setting == BASE_HEX) && c == CH_ZERO)
        begin
            active_radix = radix_setting;
            accum        = '0;
            parse_phase  = PH_ZERO;
            bump_position();
        end
        else
        begin
            active_radix = (radix_setting == BASE_AUTO) ? BASE_DEC : radix_setting;
            parse_phase  = PH_DIGITS;
            take_digit(c);
        end
    endfunction

    function automatic void parse_byte(input logic [7:0] c, input logic restart);
        if (restart)
            restart_parse();
        case (parse_phase)
            PH_SPACE:
            begin
                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                    bump_position();
                else if (c == CH_PLUS || c == CH_MINUS)
                begin
                    negative    = (c == CH_MINUS);
                    parse_phase = PH_SIGNED;
                    bump_position();
                end
                else
                    pick_radix(c);
            end
            PH_SIGNED:
                pick_radix(c);
            PH_ZERO:
            begin
                if (c == CH_LO_X || c == CH_UP_X)
                begin
                    active_radix = BASE_HEX;
                    parse_phase  = PH_DIGITS;
                    bump_position();
                end
                else
                begin
                    if (active_radix == BASE_AUTO)
                        active_radix = BASE_OCT;
                    accum       = '0;
                    parse_phase = PH_DIGITS;
                    take_digit(c);
                end
            end
            PH_DIGITS:
                take_digit(c);
            default:
                ;
        endcase
    endfunction

    function automatic void check_number();
        parsed_number_t want;
        seen++;
        if (expected_numbers.size() == 0)
        begin
            flag_mismatch($sformatf("unexpected result: value %0d end %0d nul %0b",
                                    value, end_position, ended_on_nul));
            return;
        end
        want = expected_numbers.pop_front();
        if (value !== $signed(want.value))
            flag_mismatch($sformatf("result %0d value: expected %0d, got %0d",
                                    seen, $signed(want.value), value));
        if (end_position !== want.end_pos)
            flag_mismatch($sformatf("result %0d end_position: expected %0d, got %0d",
                                    seen, want.end_pos, end_position));
        if (ended_on_nul !== want.nul)
            flag_mismatch($sformatf("result %0d ended_on_nul: expected %0b, got %0b",
                                    seen, want.nul, ended_on_nul));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_setting = BASE_AUTO;
            restart_parse();
            expected_numbers.delete();
            err_count = 0;
            seen      = 0;
            mismatches      <= 0;
            outstanding     <= 0;
            numbers_checked <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                radix_setting = number_base;
            if (in_valid && !in_stall)
                parse_byte(character, first);
            if (out_valid && !out_stall)
                check_number();
            mismatches      <= err_count;
            outstanding     <= expected_numbers.size();
            numbers_checked <= seen;
        end
    end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import aip_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned PHASE_BYTES = 60;
    localparam int unsigned NUM_PHASES  = 9;
    localparam logic [5:0]  RADIX_UNARY = 6'd1;
    localparam logic [5:0]  RADIX_BIN   = 6'd2;
    localparam logic [5:0]  RADIX_MAX   = 6'd36;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [5:0]               number_base;
    logic                     in_valid;
    logic                     in_stall;
    logic [7:0]               character;
    logic                     first;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [31:0]       value;
    logic [END_POS_WIDTH-1:0] end_position;
    logic                     ended_on_nul;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned numbers_checked;
    int unsigned cycle_count;
    int unsigned bytes_sent;
    int unsigned strings_sent;
    int unsigned trailing;
    bit          tx_quiet;
    bit          rx_quiet;
    bit          hold_req;
    logic [7:0]  text[$];

    ascii_integer_parser_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .number_base  (number_base),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .character    (character),
        .first        (first),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .value        (value),
        .end_position (end_position),
        .ended_on_nul (ended_on_nul)
    );

    aip_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .number_base     (number_base),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .character       (character),
        .first           (first),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .value           (value),
        .end_position    (end_position),
        .ended_on_nul    (ended_on_nul),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .numbers_checked (numbers_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycle_count, outstanding);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: random stall after each beat, occasional stall while empty,
    // and one long hold on request.
    initial
    begin : result_sink
        int unsigned wait_left;
        wait_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                wait_left = rx_quiet ? 0 : $urandom_range(0, 8);
            else if (wait_left == 0 && !rx_quiet && $urandom_range(0, 15) == 0)
                wait_left = $urandom_range(1, 8);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                wait_left = LONG_HOLD;
            end
            if (wait_left != 0)
            begin
                out_stall <= 1'b1;
                wait_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic send_byte(input logic [7:0] c, input logic f);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        character <= c;
        first     <= f;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text(input bit lead);
        foreach (text[i])
            send_byte(text[i], lead && (i == 0));
        strings_sent++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
    endtask

    // Drop valid and hold until every parsed number has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_base(input logic [5:0] b);
        wait_drained();
        cfg_valid   <= 1'b1;
        number_base <= b;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_space();
        if ($urandom_range(0, 5) == 0)
            return CH_SPACE;
        return 8'(CH_TAB + $urandom_range(0, 4));
    endfunction

    function automatic logic [7:0] digit_char(input int unsigned radix);
        int unsigned d;
        d = $urandom_range(0, radix - 1);
        if (d < 10)
            return 8'(CH_ZERO + d);
        return 8'(($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + d - 10);
    endfunction

    // Mostly well-formed numbers with random content, some pure noise.
    task automatic build_random_text(input logic [5:0] b);
        int unsigned radix;
        int unsigned k;
        text.delete();
        trailing = 0;
        if ($urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 3)) text.push_back(pick_space());
        k = $urandom_range(0, 3);
        if (k == 1)
            text.push_back(CH_PLUS);
        else if (k == 2)
            text.push_back(CH_MINUS);
        radix = (b == BASE_AUTO) ? BASE_DEC : b;
        if ((b == BASE_AUTO || b == BASE_HEX) && $urandom_range(0, 2) != 0)
        begin
            text.push_back(CH_ZERO);
            if ($urandom_range(0, 3) != 0)
            begin
                text.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
                radix = BASE_HEX;
            end
            else if (b == BASE_AUTO)
                radix = BASE_OCT;
        end
        repeat ($urandom_range(0, 12)) text.push_back(digit_char(radix));
        text.push_back(($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255)) : CH_NUL);
        trailing = $urandom_range(0, 2);
        repeat (trailing) text.push_back(8'($urandom_range(0, 255)));
    endtask

    initial
    begin : stimulus
        logic [5:0]  radix_plan[NUM_PHASES];
        int unsigned live;
        bit          paused;

        rst_n       = 1'b0;
        cycle_count = 0;
        bytes_sent  = 0;
        strings_sent = 0;
        tx_quiet    = 1'b0;
        rx_quiet    = 1'b0;
        hold_req    = 1'b0;
        paused      = 1'b0;
        cfg_valid   <= 1'b0;
        number_base <= BASE_AUTO;
        in_valid    <= 1'b0;
        character   <= CH_NUL;
        first       <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every whitespace kind, plus sign, stop on 0xFF; no leading first after reset.
        text.delete();
        text.push_back(CH_SPACE);
        for (int k = 0; k <= CH_CR - CH_TAB; k++)
            text.push_back(8'(CH_TAB + k));
        add_text("+42");
        text.push_back(8'hFF);
        send_text(1'b0);

        // Hex prefix with no hex digit after it.
        text.delete();
        add_text("-0xg");
        send_text(1'b1);

        text.delete();
        add_text("0X7fffffff");
        text.push_back(CH_NUL);
        send_text(1'b1);

        // Octal stops at 9.
        text.delete();
        add_text("0179");
        send_text(1'b1);

        // Sign alone, sign then junk, empty string.
        text.delete();
        add_text("-");
        text.push_back(CH_NUL);
        send_text(1'b1);
        text.delete();
        add_text("+z");
        send_text(1'b1);
        text.delete();
        text.push_back(CH_NUL);
        send_text(1'b1);

        // Bytes after the end are ignored.
        text.delete();
        add_text("55");
        send_text(1'b0);

        // Wrap modulo 2^32 both ways.
        text.delete();
        add_text("4294967297");
        text.push_back(CH_NUL);
        send_text(1'b1);
        text.delete();
        add_text("-2147483648");
        text.push_back(CH_NUL);
        send_text(1'b1);

        // Restart in the middle of a number.
        text.delete();
        add_text("12");
        send_text(1'b1);
        text.delete();
        add_text("3");
        text.push_back(CH_NUL);
        send_text(1'b1);

        radix_plan = '{BASE_DEC, RADIX_UNARY, RADIX_MAX, BASE_HEX, BASE_AUTO, BASE_OCT,
                       RADIX_BIN, 6'($urandom_range(3, 35)), BASE_AUTO};
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_base(radix_plan[p]);
            if (p == 2)
                hold_req = 1'b1;
            live = 0;
            while (live < PHASE_BYTES)
            begin
                tx_quiet = ($urandom_range(0, 5) == 0);
                rx_quiet = ($urandom_range(0, 5) == 0);
                build_random_text(radix_plan[p]);
                send_text(1'b1);
                live += text.size() - trailing;
                if (p == 4 && !paused && live >= PHASE_BYTES / 2)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;

        wait_drained();
        repeat (10) @(posedge clk);
        $display("Sent %0d bytes in %0d strings over %0d radix settings, %0d numbers checked.",
                 bytes_sent, strings_sent, NUM_PHASES + 1, numbers_checked);
        $display("Included a %0d-cycle output hold and a full drain in mid-stream.",
                 LONG_HOLD);
        if (mismatches == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
